// File: rtl/pio_dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pio_dec_pkg
// shared types and constants of the port i/o decoder
// ----------------------------------------------------------------------------
package pio_dec_pkg;

  localparam int unsigned SPACE_BYTES_DEF  = 65536;
  localparam int unsigned WINDOW_COUNT_DEF = 8;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned LAST_W    = ADDR_W + 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned LANE_W    = 2;
  localparam int unsigned WIN_W     = 33;
  localparam int unsigned WIN_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 4;

  localparam int unsigned WIN_EN_BIT  = 32;
  localparam int unsigned WIN_HI_LSB  = 16;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COUNT = 2'd1,
    STATUS_PAST_END  = 2'd2
  } status_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic err;
    logic last_byte;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/port_io_space_with_range_decode_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// port_io_space_with_range_decode_top
// port-mapped i/o space with first-match address window decode
// ----------------------------------------------------------------------------
// results: done_o pulses once an accepted access completes or is rejected;
//   results cannot be stalled
// throughput: a new transaction is taken only after the last one's result, one
//   byte per cycle through the single-port byte-wide port space ram
// reset: windows disabled; busy stays high while the port space is cleared
//   (config writes are taken during that time)
module port_io_space_with_range_decode_top #(
  parameter int unsigned SPACE_BYTES  = pio_dec_pkg::SPACE_BYTES_DEF,
  parameter int unsigned WINDOW_COUNT = pio_dec_pkg::WINDOW_COUNT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              op_i,
  input  wire logic [pio_dec_pkg::ADDR_W-1:0]    port_addr_i,
  input  wire logic [pio_dec_pkg::CNT_W-1:0]     byte_count_i,
  input  wire logic [pio_dec_pkg::DATA_W-1:0]    write_data_i,
  output logic                                   done_o,
  output logic      [pio_dec_pkg::DATA_W-1:0]    read_data_o,
  output logic                                   window_hit_o,
  output logic      [pio_dec_pkg::WIN_IDX_W-1:0] window_index_o,
  output logic      [1:0]                        status_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pio_dec_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pio_dec_pkg::WIN_W-1:0]     cfg_data_i
);

  import pio_dec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pio_dec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  pio_dec_dp #(
    .SPACE_BYTES  (SPACE_BYTES),
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .port_addr_i    (port_addr_i),
    .byte_count_i   (byte_count_i),
    .write_data_i   (write_data_i),
    .read_data_o    (read_data_o),
    .window_hit_o   (window_hit_o),
    .window_index_o (window_index_o),
    .status_o       (status_o)
  );

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted transaction did not raise busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |->
      ((read_data_o == '0) && !window_hit_o && (window_index_o == '0)))
    else $error("rejected transaction returned nonzero fields");

  a_miss_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !window_hit_o) |-> (window_index_o == '0))
    else $error("window index set without a hit");

endmodule

`default_nettype wire

// File: rtl/pio_dec_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pio_dec_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module pio_dec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pio_dec_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pio_dec_ctrl
// controller: memory clear after reset, access sequencing, result strobe
// ----------------------------------------------------------------------------
module pio_dec_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire pio_dec_pkg::sts_t sts_i,
  output pio_dec_pkg::cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  import pio_dec_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_XFER,
    ST_DRAIN,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_done) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CHECK;
            busy_q  <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (sts_i.err) begin
            state_q <= ST_RESP;
            done_q  <= 1'b1;
          end else begin
            state_q <= ST_XFER;
          end
        end
        ST_XFER: begin
          if (sts_i.last_byte) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_RESP;
          done_q  <= 1'b1;
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.clear = (state_q == ST_CLEAR);
    cmd_o.load  = (state_q == ST_IDLE) && start;
    cmd_o.check = (state_q == ST_CHECK);
    cmd_o.step  = (state_q == ST_XFER);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/pio_dec_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pio_dec_dp
// datapath: window registers, range decode, byte-serial port space access
// ----------------------------------------------------------------------------
module pio_dec_dp #(
  parameter int unsigned SPACE_BYTES  = pio_dec_pkg::SPACE_BYTES_DEF,
  parameter int unsigned WINDOW_COUNT = pio_dec_pkg::WINDOW_COUNT_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pio_dec_pkg::cmd_t                    cmd_i,
  output pio_dec_pkg::sts_t                         sts_o,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [pio_dec_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pio_dec_pkg::WIN_W-1:0]        cfg_data_i,
  input  wire logic                                 op_i,
  input  wire logic [pio_dec_pkg::ADDR_W-1:0]       port_addr_i,
  input  wire logic [pio_dec_pkg::CNT_W-1:0]        byte_count_i,
  input  wire logic [pio_dec_pkg::DATA_W-1:0]       write_data_i,
  output logic      [pio_dec_pkg::DATA_W-1:0]       read_data_o,
  output logic                                      window_hit_o,
  output logic      [pio_dec_pkg::WIN_IDX_W-1:0]    window_index_o,
  output logic      [1:0]                           status_o
);

  import pio_dec_pkg::*;

  localparam int unsigned AW = $clog2(SPACE_BYTES);

  logic [WIN_W-1:0]     win_q [WINDOW_COUNT];

  logic                 op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     count_q;
  logic [DATA_W-1:0]    wdata_q;
  logic [LANE_W-1:0]    idx_q;
  logic [DATA_W-1:0]    rdata_q;
  logic                 rd_pend_q;
  logic [LANE_W-1:0]    rd_lane_q;
  logic [AW-1:0]        clr_q;
  status_e              status_q;
  logic                 hit_q;
  logic [WIN_IDX_W-1:0] widx_q;

  logic [LAST_W-1:0]    last_addr;
  logic                 count_ok;
  logic                 past_end;
  status_e              status_d;
  logic                 hit_d;
  logic [WIN_IDX_W-1:0] widx_d;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  // window registers
  for (genvar i = 0; i < WINDOW_COUNT; i++) begin : g_win
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_q[i] <= '0;
      end else if (cfg_valid_i && (cfg_index_i == CFG_IDX_W'(i))) begin
        win_q[i] <= cfg_data_i;
      end
    end
  end

  // access checks and range decode
  always_comb begin
    count_ok  = (count_q inside {3'd1, 3'd2, 3'd4});
    last_addr = {1'b0, addr_q} + LAST_W'(count_q) - LAST_W'(1);
    past_end  = (last_addr >= LAST_W'(SPACE_BYTES));
    hit_d     = 1'b0;
    widx_d    = '0;
    for (int i = WINDOW_COUNT - 1; i >= 0; i--) begin
      if (win_q[i][WIN_EN_BIT] &&
          (addr_q >= win_q[i][WIN_HI_LSB-1:0]) &&
          (last_addr[ADDR_W-1:0] <= win_q[i][WIN_EN_BIT-1:WIN_HI_LSB])) begin
        hit_d  = 1'b1;
        widx_d = WIN_IDX_W'(i);
      end
    end
    if (!count_ok) begin
      status_d = STATUS_BAD_COUNT;
    end else if (past_end) begin
      status_d = STATUS_PAST_END;
    end else begin
      status_d = STATUS_OK;
    end
    if (status_d != STATUS_OK) begin
      hit_d  = 1'b0;
      widx_d = '0;
    end
  end

  // transaction registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_lane_q <= '0;
      clr_q     <= '0;
      status_q  <= STATUS_OK;
      hit_q     <= 1'b0;
      widx_q    <= '0;
    end else begin
      rd_pend_q <= cmd_i.step && !op_q;
      rd_lane_q <= idx_q;
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + LANE_W'(1);
      end
      if (cmd_i.check) begin
        status_q <= status_d;
        hit_q    <= hit_d;
        widx_q   <= widx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      addr_q  <= port_addr_i;
      count_q <= byte_count_i;
      wdata_q <= write_data_i;
      rdata_q <= '0;
    end else if (rd_pend_q) begin
      rdata_q[{rd_lane_q, 3'b000} +: 8] <= ram_rdata;
    end
  end

  // port space
  always_comb begin
    ram_we    = cmd_i.clear || (cmd_i.step && op_q);
    ram_re    = cmd_i.step && !op_q;
    ram_addr  = cmd_i.clear ? clr_q : (addr_q[AW-1:0] + AW'(idx_q));
    ram_wdata = cmd_i.clear ? 8'h00 : wdata_q[{idx_q, 3'b000} +: 8];
  end

  pio_dec_ram #(
    .WIDTH (8),
    .DEPTH (SPACE_BYTES)
  ) u_space (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o           = '0;
    sts_o.clr_done  = (clr_q == AW'(SPACE_BYTES - 1));
    sts_o.err       = (status_d != STATUS_OK);
    sts_o.last_byte = (idx_q == LANE_W'(count_q - CNT_W'(1)));
  end

  assign read_data_o    = rdata_q;
  assign window_hit_o   = hit_q;
  assign window_index_o = widx_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

// File: verif/port_io_space_with_range_decode_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_io_space_with_range_decode_top_test
// self-checking test of the port i/o space and its first-match window
// decode: directed accesses at the edges of the space and the windows, then
// random read/write traffic under several window settings, each result
// checked against a local model of the space and the windows
// ----------------------------------------------------------------------------
module port_io_space_with_range_decode_top_test;

  import pio_dec_pkg::*;

  localparam int unsigned WIN_REG_COUNT = 8;
  localparam int unsigned WIN_SEL_W     = $clog2(WIN_REG_COUNT);
  localparam int unsigned CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;
  localparam logic        OP_READ       = 1'b0;
  localparam logic        OP_WRITE      = 1'b1;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic                 window_hit;
    logic [WIN_IDX_W-1:0] window_index;
    status_e              status;
  } access_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 op_i;
  logic [ADDR_W-1:0]    port_addr_i;
  logic [CNT_W-1:0]     byte_count_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 done_o;
  logic [DATA_W-1:0]    read_data_o;
  logic                 window_hit_o;
  logic [WIN_IDX_W-1:0] window_index_o;
  logic [1:0]           status_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WIN_W-1:0]     cfg_data_i;

  logic [7:0]           port_mem [0:SPACE_BYTES_DEF-1];
  logic [WIN_W-1:0]     window_regs [0:WIN_REG_COUNT-1];
  access_result_t       pending_results [$];
  int unsigned          mismatch_count;

  port_io_space_with_range_decode_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .port_addr_i    (port_addr_i),
    .byte_count_i   (byte_count_i),
    .write_data_i   (write_data_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .window_hit_o   (window_hit_o),
    .window_index_o (window_index_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("port_io_space_with_range_decode_top_test failed");
    $finish;
  end

  // model of one access: updates the space and returns the decoded result
  function automatic access_result_t decode_access(input logic wr,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [CNT_W-1:0] cnt,
                                                   input logic [DATA_W-1:0] wdata);
    access_result_t res;
    int unsigned    last_port;
    logic [WIN_W-1:0] w;
    res = '0;
    res.status = STATUS_OK;
    if (!(cnt == 3'd1 || cnt == 3'd2 || cnt == 3'd4)) begin
      res.status = STATUS_BAD_COUNT;
      return res;
    end
    last_port = int'(addr) + int'(cnt) - 1;
    if (last_port >= SPACE_BYTES_DEF) begin
      res.status = STATUS_PAST_END;
      return res;
    end
    for (int i = 0; i < int'(cnt); i++) begin
      if (wr == OP_WRITE) begin
        port_mem[addr + ADDR_W'(i)] = wdata[8*i +: 8];
      end else begin
        res.read_data[8*i +: 8] = port_mem[addr + ADDR_W'(i)];
      end
    end
    for (int i = 0; i < WINDOW_COUNT_DEF && i < WIN_REG_COUNT; i++) begin
      w = window_regs[i];
      if (!res.window_hit && w[WIN_EN_BIT] && addr >= w[WIN_HI_LSB-1:0] &&
          last_port <= int'(w[WIN_EN_BIT-1:WIN_HI_LSB])) begin
        res.window_hit   = 1'b1;
        res.window_index = WIN_IDX_W'(i);
      end
    end
    return res;
  endfunction

  initial begin
    foreach (port_mem[a]) port_mem[a] = '0;
    foreach (window_regs[i]) window_regs[i] = '0;
  end

  // result check first, then prediction of a newly accepted transaction
  always @(posedge clk_i) begin : result_monitor
    access_result_t want;
    access_result_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.read_data    = read_data_o;
        got.window_hit   = window_hit_o;
        got.window_index = window_index_o;
        got.status       = status_e'(status_o);
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: data %h hit %b index %0d status %0d",
                     got.read_data, got.window_hit, got.window_index, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"mismatch: expected data %h hit %b index %0d status %0d, ",
                        "got data %h hit %b index %0d status %0d"},
                       want.read_data, want.window_hit, want.window_index, want.status,
                       got.read_data, got.window_hit, got.window_index, got.status);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(decode_access(op_i, port_addr_i, byte_count_i,
                                                write_data_i));
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < WIN_REG_COUNT)
        window_regs[cfg_index_i[WIN_SEL_W-1:0]] = cfg_data_i;
    end
  end

  // leaves start high so that back-to-back transactions need no second assignment
  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] wdata);
    start        <= 1'b1;
    op_i         <= wr;
    port_addr_i  <= addr;
    byte_count_i <= cnt;
    write_data_i <= wdata;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [WIN_W-1:0] window_value(input logic en, input int unsigned first,
                                                    input int unsigned last);
    return {en, 16'(last), 16'(first)};
  endfunction

  function automatic logic [WIN_W-1:0] rand_window();
    int unsigned first;
    int unsigned sel;
    sel   = $urandom_range(0, 9);
    first = $urandom_range(0, 240);
    case (sel)
      0: return '0;
      1: return '1;
      2: return {1'($urandom_range(0, 1)), 32'($urandom)};
      3: return window_value(1'b0, first, first + $urandom_range(0, 64));
      4: return window_value(1'b1, first + 1, first);
      5: return window_value(1'b1, 16'hFFC0 + $urandom_range(0, 31), 16'hFFFF);
      default: return window_value(1'b1, first, first + $urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [WIN_W-1:0] w;
    int unsigned      sel;
    sel = $urandom_range(0, 9);
    w   = window_regs[WIN_SEL_W'($urandom_range(0, WIN_REG_COUNT - 1))];
    case (sel)
      0, 1, 2, 3, 4: return ADDR_W'($urandom_range(0, 255));
      5: return ADDR_W'(16'hFFF0 + $urandom_range(0, 15));
      6: return ADDR_W'($urandom);
      7: return w[WIN_HI_LSB-1:0] + ADDR_W'($urandom_range(0, 2)) - ADDR_W'(1);
      default: return w[WIN_EN_BIT-1:WIN_HI_LSB] - ADDR_W'($urandom_range(0, 4)) + ADDR_W'(1);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      case ($urandom_range(0, 2))
        0: return CNT_W'(1);
        1: return CNT_W'(2);
        default: return CNT_W'(4);
      endcase
    end
    return CNT_W'($urandom_range(0, 7));
  endfunction

  task automatic test_reset_state();
    send_access(OP_READ, 16'h0000, 3'd4, 32'h0);
    send_access(OP_READ, 16'hFFFC, 3'd4, 32'hFFFF_FFFF);
    send_access(OP_READ, 16'hFFFF, 3'd1, 32'h0);
    drain_results();
  endtask

  task automatic test_directed_windows();
    write_window(4'd0, window_value(1'b1, 16'h0010, 16'h001F));
    write_window(4'd1, window_value(1'b0, 16'h0000, 16'hFFFF));
    write_window(4'd2, window_value(1'b1, 16'h0040, 16'h003F));
    write_window(4'd3, window_value(1'b1, 16'h0040, 16'h0040));
    write_window(4'd4, window_value(1'b1, 16'h0000, 16'h000F));
    write_window(4'd5, '1);
    write_window(4'd6, '0);
    write_window(4'd7, window_value(1'b1, 16'h0000, 16'hFFFF));
    write_window(CFG_IDX_W'(WIN_REG_COUNT), '1);
    write_window(CFG_IDX_W'(CFG_IDX_MAX), '1);
    send_access(OP_WRITE, 16'h0010, 3'd4, 32'hA5A5_5A5A);
    send_access(OP_READ,  16'h0010, 3'd4, 32'h0);
    send_access(OP_WRITE, 16'h001E, 3'd4, 32'hFFFF_FFFF);
    send_access(OP_READ,  16'h001F, 3'd1, 32'h0);
    send_access(OP_READ,  16'h001E, 3'd2, 32'h0);
    send_access(OP_WRITE, 16'h0040, 3'd1, 32'h0000_00C3);
    send_access(OP_READ,  16'h0040, 3'd2, 32'h0);
    send_access(OP_WRITE, 16'h0000, 3'd2, 32'h1234_5678);
    send_access(OP_READ,  16'h0000, 3'd4, 32'h0);
    send_access(OP_WRITE, 16'h0010, 3'd3, 32'h0);
    send_access(OP_WRITE, 16'h0010, 3'd0, 32'h0);
    send_access(OP_READ,  16'h0010, 3'd5, 32'h0);
    send_access(OP_WRITE, 16'h0011, 3'd6, 32'h0);
    send_access(OP_READ,  16'h0012, 3'd7, 32'h0);
    send_access(OP_WRITE, 16'hFFFF, 3'd2, 32'hFFFF_FFFF);
    send_access(OP_READ,  16'hFFFD, 3'd4, 32'h0);
    send_access(OP_WRITE, 16'hFFFC, 3'd4, 32'hDEAD_BEEF);
    send_access(OP_READ,  16'hFFFF, 3'd1, 32'h0);
    send_access(OP_READ,  16'h0010, 3'd4, 32'h0);
    send_access(OP_READ,  16'hFFFC, 3'd4, 32'h0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    int unsigned idle_pct;
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < WIN_REG_COUNT; i++) begin
        if (p == 0)
          write_window(CFG_IDX_W'(i), '0);
        else if (p == 1)
          write_window(CFG_IDX_W'(i), '1);
        else
          write_window(CFG_IDX_W'(i), rand_window());
      end
      write_window(CFG_IDX_W'($urandom_range(WIN_REG_COUNT, CFG_IDX_MAX)), WIN_W'($urandom));
      idle_pct = (p == phases - 1) ? 0 : $urandom_range(0, 50);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 99) < idle_pct)
          hold_off($urandom_range(1, 9));
        else if (idle_pct != 0 && $urandom_range(0, 49) == 0)
          drain_results();
        send_access(1'($urandom_range(0, 1)), rand_addr(), rand_count(), 32'($urandom));
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OP_READ;
    port_addr_i    = '0;
    byte_count_i   = '0;
    write_data_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_windows();
    test_random_traffic(5, 86);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("port_io_space_with_range_decode_top_test passed");
    else
      $display("port_io_space_with_range_decode_top_test failed");
    $finish;
  end

endmodule
